FILE: sv/rsr_pkg.sv
`default_nettype none
package rsr_pkg;

   // field widths fixed by the item format
   localparam int SAMPLE_W = 16;
   localparam int VALUE_W  = 48;
   localparam int SUM_W    = 29;
   localparam int SQSUM_W  = 43;
   localparam int COUNT_W  = 13;
   localparam int EXT_W    = 17;
   localparam int MODE_W   = 3;

   localparam int MAX_RUN_DEF = 4096;

   // statistic codes
   localparam logic [MODE_W-1:0] MODE_MEAN   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUM    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_VAR    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STD    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MIN    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_MAX    = 3'd5;
   localparam logic [MODE_W-1:0] MODE_ABSMAX = 3'd6;
   localparam logic [MODE_W-1:0] MODE_MAGMAX = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       sample_finite;
      logic                       run_end;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] stat_value;
      logic                      stat_defined;
   } rsp_type;

   // run summary handed from front to back
   typedef struct packed {
      logic [MODE_W-1:0]         statistic;
      logic signed [SUM_W-1:0]   sum;
      logic [SQSUM_W-1:0]        sqsum;
      logic [COUNT_W-1:0]        count;
      logic signed [EXT_W-1:0]   extreme;
      logic                      seen;
   } job_type;

endpackage
`default_nettype wire

FILE: sv/rsr_front.sv
`default_nettype none
module rsr_front
   import rsr_pkg::*;
#(
   parameter int MAX_RUN = MAX_RUN_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [MODE_W-1:0] csr_data,
   input  wire logic    queue_full,
   output logic         push,
   output job_type      push_job
);

   logic [MODE_W-1:0]       statistic_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQSUM_W-1:0]      sqsum_ff, sqsum_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic signed [EXT_W-1:0] extreme_ff, extreme_in;
   logic                    seen_ff, seen_in;

   logic                    accept, take;
   logic signed [EXT_W-1:0] s_ext, mag_s, mag_e;
   logic signed [31:0]      sq;

   assign req_stall = queue_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid & ~queue_full;

   // statistic register
   always_ff @(posedge clock) begin
      if (reset) begin
         statistic_ff <= MODE_MEAN;
      end else if (csr_valid) begin
         statistic_ff <= csr_data;
      end
   end

   // sample classification and next run state
   always_comb begin
      s_ext = EXT_W'(req_data.sample);
      mag_s = s_ext[EXT_W-1] ? -s_ext : s_ext;
      mag_e = extreme_ff[EXT_W-1] ? -extreme_ff : extreme_ff;
      sq    = req_data.sample * req_data.sample;
      take  = req_data.sample_finite && (count_ff < COUNT_W'(MAX_RUN));

      sum_in     = sum_ff;
      sqsum_in   = sqsum_ff;
      count_in   = count_ff;
      extreme_in = extreme_ff;
      seen_in    = seen_ff;
      if (take) begin
         sum_in   = sum_ff + SUM_W'(req_data.sample);
         sqsum_in = sqsum_ff + {{(SQSUM_W-32){1'b0}}, sq};
         count_in = count_ff + 1'b1;
         seen_in  = 1'b1;
         case (statistic_ff)
            MODE_MIN: begin
               if (!seen_ff || s_ext < extreme_ff) extreme_in = s_ext;
            end
            MODE_MAX: begin
               if (!seen_ff || s_ext > extreme_ff) extreme_in = s_ext;
            end
            MODE_ABSMAX: begin
               if (!seen_ff || mag_s > mag_e) extreme_in = mag_s;
            end
            MODE_MAGMAX: begin
               if (!seen_ff || mag_s > mag_e) extreme_in = s_ext;
            end
            default: begin
               extreme_in = extreme_ff;
            end
         endcase
      end
   end

   // hand the finished run to the back end
   assign push               = accept & req_data.run_end;
   assign push_job.statistic = statistic_ff;
   assign push_job.sum       = sum_in;
   assign push_job.sqsum     = sqsum_in;
   assign push_job.count     = count_in;
   assign push_job.extreme   = extreme_in;
   assign push_job.seen      = seen_in;

   // run accumulators
   always_ff @(posedge clock) begin
      if (reset || push) begin
         sum_ff     <= '0;
         sqsum_ff   <= '0;
         count_ff   <= '0;
         extreme_ff <= '0;
         seen_ff    <= 1'b0;
      end else if (accept) begin
         sum_ff     <= sum_in;
         sqsum_ff   <= sqsum_in;
         count_ff   <= count_in;
         extreme_ff <= extreme_in;
         seen_ff    <= seen_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/rsr_queue.sv
`default_nettype none
module rsr_queue
   import rsr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output logic         pop_valid,
   output job_type      pop_job
);

   job_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] fill_ff;

   assign full      = (fill_ff == 2'd2);
   assign pop_valid = (fill_ff != 2'd0);
   assign pop_job   = mem_ff[rd_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule
`default_nettype wire

FILE: sv/rsr_back.sv
`default_nettype none
module rsr_back
   import rsr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   input  wire job_type job,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int PROD_W = 56;
   localparam int DEN_W  = 24;
   localparam int DQ_W   = 71;
   localparam int RAD_W  = 48;
   localparam int ROOT_W = 24;
   localparam int SREM_W = 26;
   localparam int ABS_W  = 28;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_SQRT  = 3'd4;

   logic [2:0]         state_ff;
   job_type            job_ff;
   logic [PROD_W-1:0]  a_ff, b_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [DQ_W-1:0]    dq_ff;
   logic               neg_ff;
   logic [6:0]         step_ff;
   logic [RAD_W-1:0]   rad_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [SREM_W-1:0]  srem_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic [ABS_W-1:0]   abs_sum;
   logic [PROD_W-1:0]  num;
   logic [DEN_W:0]     div_t;
   logic               div_ge;
   logic [SREM_W+1:0]  sq_t, sq_trial;
   logic               sq_ge;
   logic [VALUE_W-1:0] q48;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pop       = (state_ff == ST_IDLE) && job_valid && (!rsp_valid_ff || !rsp_stall);

   // datapath helpers
   always_comb begin
      abs_sum  = job_ff.sum[SUM_W-1] ? ABS_W'(-job_ff.sum) : ABS_W'(job_ff.sum);
      num      = (a_ff > b_ff) ? (a_ff - b_ff) : '0;
      div_t    = {rem_ff, dq_ff[DQ_W-1]};
      div_ge   = div_t >= {1'b0, den_ff};
      sq_t     = {srem_ff, rad_ff[RAD_W-1 -: 2]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_ge    = sq_t >= sq_trial;
      q48      = dq_ff[VALUE_W-1:0];
   end

   // sequencer: products, shared divider, square root
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  job_ff   <= job;
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               a_ff     <= PROD_W'(job_ff.count) * PROD_W'(job_ff.sqsum);
               b_ff     <= PROD_W'(abs_sum) * PROD_W'(abs_sum);
               den_ff   <= DEN_W'(job_ff.count) * DEN_W'(job_ff.count - 1'b1);
               state_ff <= ST_SETUP;
            end
            ST_SETUP: begin
               rem_ff  <= '0;
               step_ff <= '0;
               neg_ff  <= job_ff.sum[SUM_W-1];
               case (job_ff.statistic)
                  MODE_MEAN: begin
                     if (job_ff.count == '0) begin
                        rsp_data_ff  <= '{stat_value: '0, stat_defined: 1'b0};
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end else begin
                        dq_ff    <= {{(DQ_W-ABS_W-8){1'b0}}, abs_sum, 8'd0};
                        den_ff   <= DEN_W'(job_ff.count);
                        state_ff <= ST_DIV;
                     end
                  end
                  MODE_SUM: begin
                     rsp_data_ff  <= '{stat_value: VALUE_W'(job_ff.sum) <<< 8,
                                      stat_defined: 1'b1};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
                  MODE_VAR, MODE_STD: begin
                     if (job_ff.count < COUNT_W'(2)) begin
                        rsp_data_ff  <= '{stat_value: '0, stat_defined: 1'b0};
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end else begin
                        dq_ff    <= {num[DQ_W-17:0], 16'd0};
                        state_ff <= ST_DIV;
                     end
                  end
                  default: begin
                     if (job_ff.seen) begin
                        rsp_data_ff <= '{stat_value: VALUE_W'(job_ff.extreme) <<< 8,
                                         stat_defined: 1'b1};
                     end else begin
                        rsp_data_ff <= '{stat_value: '0, stat_defined: 1'b0};
                     end
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               endcase
            end
            ST_DIV: begin
               if (step_ff == 7'(DQ_W)) begin
                  step_ff <= '0;
                  case (job_ff.statistic)
                     MODE_MEAN: begin
                        rsp_data_ff  <= '{stat_value: neg_ff ? -q48 : q48,
                                         stat_defined: 1'b1};
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                     MODE_STD: begin
                        rad_ff   <= dq_ff[RAD_W-1:0];
                        root_ff  <= '0;
                        srem_ff  <= '0;
                        state_ff <= ST_SQRT;
                     end
                     default: begin
                        rsp_data_ff  <= '{stat_value: dq_ff[VALUE_W+15:16],
                                         stat_defined: 1'b1};
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                  endcase
               end else begin
                  rem_ff  <= div_ge ? DEN_W'(div_t - {1'b0, den_ff}) : div_t[DEN_W-1:0];
                  dq_ff   <= {dq_ff[DQ_W-2:0], div_ge};
                  step_ff <= step_ff + 1'b1;
               end
            end
            ST_SQRT: begin
               if (step_ff == 7'(ROOT_W)) begin
                  rsp_data_ff  <= '{stat_value: VALUE_W'(root_ff), stat_defined: 1'b1};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  srem_ff <= sq_ge ? SREM_W'(sq_t - sq_trial) : SREM_W'(sq_t);
                  root_ff <= {root_ff[ROOT_W-2:0], sq_ge};
                  rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
                  step_ff <= step_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

FILE: sv/run_statistics_reducer.sv
`default_nettype none
// Run statistics reducer. Samples (Q8.8) are accumulated at one beat per
// cycle; on the beat marked run_end the run summary goes into a two-entry
// queue and the back end produces one Q31.16 result: sum, min, max and the
// magnitude modes come from the summary alone, mean and variance use the
// shared bit-serial divider, standard deviation the divider plus a 24-step
// square root. Input beats keep flowing while the back end works; req_stall
// rises only when two finished runs are waiting in the queue.
// The statistic register may be written only while the block is idle.
module run_statistics_reducer
   import rsr_pkg::*;
#(
   parameter int MAX_RUN = MAX_RUN_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [MODE_W-1:0] csr_data
);

   logic    push, full, pop, pop_valid;
   job_type push_job, pop_job;

   // accumulate samples
   rsr_front #(.MAX_RUN(MAX_RUN)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .csr_valid, .csr_ready, .csr_data,
      .queue_full(full), .push, .push_job
   );

   // run summaries waiting for the back end
   rsr_queue u_queue (
      .clock, .reset, .push, .push_job, .full,
      .pop, .pop_valid, .pop_job
   );

   // final arithmetic
   rsr_back u_back (
      .clock, .reset, .job_valid(pop_valid), .job(pop_job), .pop,
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule
`default_nettype wire

FILE: sv/rsr_checker.sv
`default_nettype none
module rsr_checker
   import rsr_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // stalled result beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // stalled result payload steady
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // undefined result reads as zero
   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.stat_defined |-> rsp_data.stat_value == '0)
      else $error("undefined result carries a value");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind run_statistics_reducer rsr_checker u_rsr_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_data
);
`default_nettype wire
